@@ hdl/tch_pkg.sv @@
`default_nettype none
package tch_pkg;
    localparam int DATA_W     = 16;
    localparam int HEAD_W     = 9;
    localparam int VEC_W      = 52;
    localparam int ANG_W      = 28;
    localparam int TABLE_LEN  = 24;
    localparam int STEPS_DEF  = 16;
    localparam int DEG_FRAC   = 16;
    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 65536);
    localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(360);

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } cordic_word_t;

    function automatic ang_t atan_entry(input int idx);
        ang_t t;
        unique case (idx)
            0: t = ANG_W'(2949120);
            1: t = ANG_W'(1740967);
            2: t = ANG_W'(919879);
            3: t = ANG_W'(466945);
            4: t = ANG_W'(234379);
            5: t = ANG_W'(117304);
            6: t = ANG_W'(58666);
            7: t = ANG_W'(29335);
            8: t = ANG_W'(14668);
            9: t = ANG_W'(7334);
            10: t = ANG_W'(3667);
            11: t = ANG_W'(1833);
            12: t = ANG_W'(917);
            13: t = ANG_W'(458);
            14: t = ANG_W'(229);
            15: t = ANG_W'(115);
            16: t = ANG_W'(57);
            17: t = ANG_W'(29);
            18: t = ANG_W'(14);
            19: t = ANG_W'(7);
            20: t = ANG_W'(4);
            21: t = ANG_W'(2);
            22: t = ANG_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction
endpackage
`default_nettype wire

@@ hdl/tch_cell.sv @@
`default_nettype none
module tch_cell #(
    parameter int STEP = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  adv,
    input  wire                  in_valid,
    input  tch_pkg::cordic_word_t in_word,
    output logic                 out_valid,
    output tch_pkg::cordic_word_t out_word
);
    import tch_pkg::*;

    logic         valid_reg;
    cordic_word_t word_reg;
    cordic_word_t word_next;
    vec_t         dx;
    vec_t         dy;

    // arithmetic shift floors, as the rotation needs
    assign dx = in_word.y >>> STEP;
    assign dy = in_word.x >>> STEP;

    always_comb
    begin
        if (!in_word.y[VEC_W-1])
        begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + atan_entry(STEP);
        end
        else
        begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - atan_entry(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule
`default_nettype wire

@@ hdl/tilt_compensated_heading_top.sv @@
`default_nettype none
// Compass heading from one magnetometer and accelerometer sample set per word.
// Pipelined: a new word is accepted every cycle while the output is not stalled.
// Stages, in order: two product stages, a sum stage, a quadrant stage,
// one CORDIC cell per step, then the fold/output register.
// A stall on the output freezes the whole chain and is passed straight back.
module tilt_compensated_heading_top #(
    parameter int CORDIC_STEPS = tch_pkg::STEPS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire signed [tch_pkg::DATA_W-1:0] accel_x,
    input  wire signed [tch_pkg::DATA_W-1:0] accel_y,
    input  wire signed [tch_pkg::DATA_W-1:0] accel_z,
    input  wire signed [tch_pkg::DATA_W-1:0] mag_x,
    input  wire signed [tch_pkg::DATA_W-1:0] mag_y,
    input  wire signed [tch_pkg::DATA_W-1:0] mag_z,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [tch_pkg::HEAD_W-1:0]       heading_deg
);
    import tch_pkg::*;

    localparam int NCELL = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: negate and form pair products (17x17)
    logic signed [16:0] gx, gy, gz, mx, my, mz;
    assign gx = 17'(accel_x);
    assign gy = -17'(accel_y);
    assign gz = -17'(accel_z);
    assign mx = -17'(mag_x);
    assign my = -17'(mag_y);
    assign mz = -17'(mag_z);

    logic              v1_reg;
    logic signed [33:0] gzz_reg, gxz_reg, gxy_reg, gyy_reg, hy1_reg, hy2_reg;
    logic signed [16:0] mx1_reg, my1_reg, mz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gzz_reg <= gz * gz;
            gxz_reg <= gx * gz;
            gxy_reg <= gx * gy;
            gyy_reg <= gy * gy;
            hy1_reg <= gy * mz;
            hy2_reg <= gz * my;
            mx1_reg <= mx;
            my1_reg <= my;
            mz1_reg <= mz;
        end
    end

    // stage 2: second products
    logic               v2_reg;
    logic signed [50:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [34:0] hyd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= 51'(gzz_reg * mx1_reg);
            p2_reg  <= 51'(gxz_reg * mz1_reg);
            p3_reg  <= 51'(gxy_reg * my1_reg);
            p4_reg  <= 51'(gyy_reg * mx1_reg);
            hyd_reg <= 35'(hy1_reg) - 35'(hy2_reg);
        end
    end

    // stage 3: sums
    logic v3_reg;
    vec_t hx_reg, hy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hx_reg <= VEC_W'(p1_reg) - VEC_W'(p2_reg) - VEC_W'(p3_reg) + VEC_W'(p4_reg);
            hy_reg <= VEC_W'(hyd_reg) <<< 6;
        end
    end

    // stage 4: left half plane fold
    logic         v4_reg;
    logic         zero4_reg;
    cordic_word_t w4_reg;
    cordic_word_t w4_next;

    always_comb
    begin
        w4_next.x = hx_reg;
        w4_next.y = hy_reg;
        w4_next.z = '0;
        if (hx_reg[VEC_W-1])
        begin
            w4_next.x = -hx_reg;
            w4_next.y = -hy_reg;
            w4_next.z = hy_reg[VEC_W-1] ? -HALF_TURN : HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w4_reg    <= w4_next;
            zero4_reg <= (hx_reg == '0) && (hy_reg == '0);
        end
    end

    // cordic chain, zero flag rides alongside
    logic         cv [NCELL+1];
    cordic_word_t cw [NCELL+1];
    logic         zf [NCELL+1];

    assign cv[0] = v4_reg;
    assign cw[0] = w4_reg;
    assign zf[0] = zero4_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic zf_reg;

        tch_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_valid (cv[i]),
            .in_word  (cw[i]),
            .out_valid(cv[i+1]),
            .out_word (cw[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
                zf_reg <= zf[i];
        end
        assign zf[i+1] = zf_reg;
    end

    // clamp, truncate toward zero, fold
    ang_t                z_cl;
    logic signed [ANG_W-DEG_FRAC-1:0] deg;
    logic [HEAD_W-1:0]   head_next;
    ang_t                zc;

    always_comb
    begin
        zc = cw[NCELL].z;
        if (zc > HALF_TURN)
            z_cl = HALF_TURN;
        else if (zc < -HALF_TURN)
            z_cl = -HALF_TURN;
        else
            z_cl = zc;
        if (z_cl[ANG_W-1])
            deg = (ANG_W-DEG_FRAC)'(-((-z_cl) >>> DEG_FRAC));
        else
            deg = (ANG_W-DEG_FRAC)'(z_cl >>> DEG_FRAC);
        if (zf[NCELL])
            head_next = '0;
        else if (deg > 0)
            head_next = FULL_TURN - HEAD_W'(deg);
        else
            head_next = HEAD_W'(-deg);
    end

    logic              ov_reg;
    logic [HEAD_W-1:0] head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= cv[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            head_reg <= head_next;
    end

    assign out_valid   = ov_reg;
    assign heading_deg = head_reg;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_deg < FULL_TURN))
        else $error("heading out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(v4_reg) && $stable(v1_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

@@ tb/tilt_compensated_heading_top_tb.sv @@
`timescale 1ns / 100ps

class heading_board;
    int unsigned heading_q[$];
    int errors;

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic signed [15:0] mx,
                              logic signed [15:0] my, logic signed [15:0] mz);
        heading_q.push_back(predict_heading(ax, ay, az, mx, my, mz));
    endfunction

    static function longint atan_q16(int idx);
        longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
            2, 1, 0};
        return t[idx];
    endfunction

    static function int unsigned predict_heading(logic signed [15:0] ax,
            logic signed [15:0] ay, logic signed [15:0] az, logic signed [15:0] mx,
            logic signed [15:0] my, logic signed [15:0] mz);
        longint gx, gy, gz, bx, by, bz, hx, hy, z, dx, dy, deg;
        gx = ax;
        gy = -longint'(ay);
        gz = -longint'(az);
        bx = -longint'(mx);
        by = -longint'(my);
        bz = -longint'(mz);
        hx = gz * gz * bx - gx * gz * bz - gx * gy * by + gy * gy * bx;
        hy = (gy * bz - gz * by) * 64;
        z = 0;
        if (hx != 0 || hy != 0)
        begin
            if (hx < 0)
            begin
                z = (hy >= 0) ? 180 * 65536 : -180 * 65536;
                hx = -hx;
                hy = -hy;
            end
            for (int i = 0; i < 16 && i < 24; i++)
            begin
                // >>> on signed longint floors
                dx = hy >>> i;
                dy = hx >>> i;
                if (hy >= 0)
                begin
                    hx += dx;
                    hy -= dy;
                    z += atan_q16(i);
                end
                else
                begin
                    hx -= dx;
                    hy += dy;
                    z -= atan_q16(i);
                end
            end
            if (z > 180 * 65536) z = 180 * 65536;
            if (z < -180 * 65536) z = -180 * 65536;
        end
        deg = z / 65536;
        return (deg > 0) ? 360 - deg : -deg;
    endfunction

    function bit check_heading(logic [8:0] got, output int unsigned want);
        if (heading_q.size() == 0)
        begin
            want = 0;
            return 0;
        end
        want = heading_q.pop_front();
        return got == want[8:0];
    endfunction
endclass

module tilt_compensated_heading_top_tb;
    import tch_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0;
    logic signed [15:0] mag_x = 0, mag_y = 0, mag_z = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [8:0] heading_deg;

    heading_board board = new();
    bit sending_done = 0;
    int results_seen = 0;
    int stall_left = 0;

    tilt_compensated_heading_top i_dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    task automatic report_mismatch(string what);
        $display("%0t: heading mismatch: %s", $realtime, what);
        board.errors++;
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 0;
            3: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
            4, 5: return $signed(16'($urandom_range(0, 255)) - 16'sd128);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic send_word(input logic signed [15:0] ax, ay, az, mx, my, mz);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        accel_x <= ax; accel_y <= ay; accel_z <= az;
        mag_x <= mx; mag_y <= my; mag_z <= mz;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        board.note_sample(ax, ay, az, mx, my, mz);
        @(negedge clk);
    endtask

    // receiver: after each word, stall for a drawn number of cycles
    always @(negedge clk)
    begin
        if (rst_n && stall_left > 0)
        begin
            out_stall <= 1;
            stall_left--;
        end
        else
            out_stall <= 0;
    end

    always @(posedge clk)
    begin
        int unsigned want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (board.heading_q.size() == 0)
                report_mismatch($sformatf("unexpected word %0d", heading_deg));
            else if (!board.check_heading(heading_deg, want))
                report_mismatch($sformatf("got %0d want %0d", heading_deg, want));
        end
    end

    initial
    begin
        logic signed [15:0] ext [4];
        ext = '{16'sh8000, 16'sh7fff, 0, 16'shffff};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: extremes, zero vector, all quadrants, flat sensor
        send_word(0, 0, 0, 0, 0, 0);
        send_word(0, 0, 64, 100, 0, 0);
        send_word(0, 0, 64, -100, 0, 0);
        send_word(0, 0, 64, 0, 100, 0);
        send_word(0, 0, 64, 0, -100, 0);
        send_word(0, 0, 64, -100, 1, 0);
        send_word(0, 0, 64, -100, -1, 0);
        send_word(0, 0, 64, 100, 100, 0);
        for (int i = 0; i < 4; i++)
            send_word(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
                      ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4]);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        for (int n = 0; n < 1900; n++)
        begin
            if (n == 900)
            begin
                in_valid <= 0;
                while (board.heading_q.size() != 0) @(negedge clk);
            end
            send_word(pick_axis(), pick_axis(), pick_axis(),
                      pick_axis(), pick_axis(), pick_axis());
        end
        in_valid <= 0;
        while (board.heading_q.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        $display("covered %0d heading words with directed extremes and random axes",
                 results_seen);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/tch_pkg.sv
hdl/tch_cell.sv
hdl/tilt_compensated_heading_top.sv
tb/tilt_compensated_heading_top_tb.sv
